// ----- rtl/des_block_cipher_unit_assert.svh -----
// Assertion macros used by the des_block_cipher_unit module.
`ifndef DES_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define DES_BLOCK_CIPHER_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/des_pkg.sv -----
package des_pkg;

  localparam int Rounds = 16;

  localparam logic [5:0] IpTab [64] = '{
    6'd57,6'd49,6'd41,6'd33,6'd25,6'd17,6'd9,6'd1, 6'd59,6'd51,6'd43,6'd35,6'd27,6'd19,6'd11,6'd3,
    6'd61,6'd53,6'd45,6'd37,6'd29,6'd21,6'd13,6'd5, 6'd63,6'd55,6'd47,6'd39,6'd31,6'd23,6'd15,6'd7,
    6'd56,6'd48,6'd40,6'd32,6'd24,6'd16,6'd8,6'd0, 6'd58,6'd50,6'd42,6'd34,6'd26,6'd18,6'd10,6'd2,
    6'd60,6'd52,6'd44,6'd36,6'd28,6'd20,6'd12,6'd4, 6'd62,6'd54,6'd46,6'd38,6'd30,6'd22,6'd14,6'd6};

  localparam logic [5:0] FpTab [64] = '{
    6'd39,6'd7,6'd47,6'd15,6'd55,6'd23,6'd63,6'd31, 6'd38,6'd6,6'd46,6'd14,6'd54,6'd22,6'd62,6'd30,
    6'd37,6'd5,6'd45,6'd13,6'd53,6'd21,6'd61,6'd29, 6'd36,6'd4,6'd44,6'd12,6'd52,6'd20,6'd60,6'd28,
    6'd35,6'd3,6'd43,6'd11,6'd51,6'd19,6'd59,6'd27, 6'd34,6'd2,6'd42,6'd10,6'd50,6'd18,6'd58,6'd26,
    6'd33,6'd1,6'd41,6'd9,6'd49,6'd17,6'd57,6'd25, 6'd32,6'd0,6'd40,6'd8,6'd48,6'd16,6'd56,6'd24};

  localparam logic [4:0] ExpTab [48] = '{
    5'd31,5'd0,5'd1,5'd2,5'd3,5'd4, 5'd3,5'd4,5'd5,5'd6,5'd7,5'd8,
    5'd7,5'd8,5'd9,5'd10,5'd11,5'd12, 5'd11,5'd12,5'd13,5'd14,5'd15,5'd16,
    5'd15,5'd16,5'd17,5'd18,5'd19,5'd20, 5'd19,5'd20,5'd21,5'd22,5'd23,5'd24,
    5'd23,5'd24,5'd25,5'd26,5'd27,5'd28, 5'd27,5'd28,5'd29,5'd30,5'd31,5'd0};

  localparam logic [4:0] PTab [32] = '{
    5'd15,5'd6,5'd19,5'd20,5'd28,5'd11,5'd27,5'd16, 5'd0,5'd14,5'd22,5'd25,5'd4,5'd17,5'd30,5'd9,
    5'd1,5'd7,5'd23,5'd13,5'd31,5'd26,5'd2,5'd8, 5'd18,5'd12,5'd29,5'd5,5'd21,5'd10,5'd3,5'd24};

  localparam logic [5:0] Pc1Tab [56] = '{
    6'd56,6'd48,6'd40,6'd32,6'd24,6'd16,6'd8,6'd0, 6'd57,6'd49,6'd41,6'd33,6'd25,6'd17,6'd9,6'd1,
    6'd58,6'd50,6'd42,6'd34,6'd26,6'd18,6'd10,6'd2, 6'd59,6'd51,6'd43,6'd35,6'd62,6'd54,6'd46,6'd38,
    6'd30,6'd22,6'd14,6'd6,6'd61,6'd53,6'd45,6'd37, 6'd29,6'd21,6'd13,6'd5,6'd60,6'd52,6'd44,6'd36,
    6'd28,6'd20,6'd12,6'd4,6'd27,6'd19,6'd11,6'd3};

  localparam logic [5:0] Pc2Tab [48] = '{
    6'd13,6'd16,6'd10,6'd23,6'd0,6'd4,6'd2,6'd27, 6'd14,6'd5,6'd20,6'd9,6'd22,6'd18,6'd11,6'd3,
    6'd25,6'd7,6'd15,6'd6,6'd26,6'd19,6'd12,6'd1, 6'd40,6'd51,6'd30,6'd36,6'd46,6'd54,6'd29,6'd39,
    6'd50,6'd44,6'd32,6'd47,6'd43,6'd48,6'd38,6'd55, 6'd33,6'd52,6'd45,6'd41,6'd49,6'd35,6'd28,6'd31};

  // cumulative left rotation of C and D after each round
  localparam logic [4:0] RotSum [16] = '{
    5'd1,5'd2,5'd4,5'd6,5'd8,5'd10,5'd12,5'd14,5'd15,5'd17,5'd19,5'd21,5'd23,5'd25,5'd27,5'd0};

  localparam logic [3:0] SboxTab [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  // table entries are 0-based positions from the MSB
  function automatic logic [63:0] perm64(input logic [63:0] v, input logic [5:0] t [64]);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[63-t[i]];
    return r;
  endfunction

  function automatic logic [55:0] rot28x2(input logic [55:0] cd, input logic [4:0] n);
    logic [55:0] c2;
    logic [55:0] d2;
    c2 = {cd[55:28], cd[55:28]} << n;
    d2 = {cd[27:0], cd[27:0]} << n;
    return {c2[55:28], d2[55:28]};
  endfunction

  function automatic logic [47:0] round_key(input logic [55:0] cd0, input logic [3:0] rnd);
    logic [55:0] cd;
    logic [47:0] k;
    cd = rot28x2(cd0, RotSum[rnd]);
    for (int i = 0; i < 48; i++) k[47-i] = cd[55-Pc2Tab[i]];
    return k;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0] b;
    for (int i = 0; i < 48; i++) x[47-i] = r[31-ExpTab[i]];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      s[31-4*i -: 4] = SboxTab[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[31-PTab[i]];
    return p;
  endfunction

endpackage

// ----- rtl/des_key_sched.sv -----
module des_key_sched import des_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output logic [47:0] round_keys [16]
);

  logic [55:0] cd;

  assign cfg_ready = 1'b1;

  // hold the PC-1 image of the key; reset key is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cd <= '0;
    end else if (cfg_valid) begin
      for (int i = 0; i < 56; i++) cd[55-i] <= cfg_data[63-Pc1Tab[i]];
    end
  end

  // round keys are registered from the held key on every clock
  always_ff @(posedge clk) begin
    for (int r = 0; r < Rounds; r++) round_keys[r] <= round_key(cd, 4'(r));
  end

endmodule

// ----- rtl/des_round.sv -----
module des_round import des_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_kind,
  input  logic [63:0] in_lr,
  input  logic [47:0] key_enc,
  input  logic [47:0] key_dec,
  output logic        out_valid,
  output logic        out_kind,
  output logic [63:0] out_lr
);

  logic [47:0] k;

  assign k = in_kind ? key_dec : key_enc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_kind <= in_kind;
    out_lr   <= {in_lr[31:0], in_lr[63:32] ^ feistel(in_lr[31:0], k)};
  end

endmodule

// ----- rtl/des_block_cipher_unit.sv -----
// DES engine, one 64-bit block per cycle. Pulse start with kind and block_in;
// busy is always low, so a block is taken every cycle. The result is on
// block_out for one cycle with done high, after the block has passed one input
// register, one register per round and one output register.
// The receiver cannot stall, so every result must be taken as it appears. A
// key written on the cfg channel takes effect for blocks taken at any edge
// after the write.
module des_block_cipher_unit import des_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [63:0] block_in,
  output logic        done,
  output logic [63:0] block_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);
  `include "des_block_cipher_unit_assert.svh"

  logic [47:0] round_keys [16];
  logic        v    [17];
  logic        kd   [17];
  logic [63:0] lr   [17];
  logic [63:0] fin;

  assign busy = 1'b0;

  des_key_sched u_keys (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .round_keys
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
      done <= 1'b0;
    end else begin
      v[0] <= start;
      done <= v[16];
    end
  end

  always_ff @(posedge clk) begin
    kd[0]     <= kind;
    lr[0]     <= perm64(block_in, IpTab);
    block_out <= perm64(fin, FpTab);
  end

  assign fin = {lr[16][31:0], lr[16][63:32]};

  for (genvar g = 0; g < Rounds; g++) begin : g_rnd
    des_round u_round (
      .clk, .rst,
      .in_valid (v[g]),
      .in_kind  (kd[g]),
      .in_lr    (lr[g]),
      .key_enc  (round_keys[g]),
      .key_dec  (round_keys[Rounds-1-g]),
      .out_valid(v[g+1]),
      .out_kind (kd[g+1]),
      .out_lr   (lr[g+1])
    );
  end

  `DES_ASSERT_NEXT(a_busy_low, clk, rst, 1'b1, !busy, "busy must stay low")
  `DES_ASSERT_NEXT(a_enter, clk, rst, start, v[0], "accepted word lost at entry")
  `DES_ASSERT_NEXT(a_exit, clk, rst, v[16], done, "word lost at pipeline exit")
  `DES_ASSERT_IMPL(a_cfg, clk, rst, cfg_valid, cfg_ready, "config write refused")

endmodule
